[rtl/core/sfca_pkg.sv]
package sfca_pkg;

    // Limits of the assembler
    localparam int SRC_MAX   = 1024;     // source vertices
    localparam int RUN_MAX   = 1024;     // vertices per run
    localparam int OUT_MAX   = 65536;    // output vertex numbering

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 10;       // vertex_index field
    localparam int VNUM_W    = 16;       // vertex_number and triangle fields
    localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);
    localparam int BASE_W    = $clog2(OUT_MAX + 1);
    localparam int OUT_TDATA_W = 144;

    // Result kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_LIST_END = 1'b1;

    // One job handed from the front to the back
    typedef struct packed {
        logic                 kind;
        logic [WORD_W-1:0]    u;
        logic [WORD_W-1:0]    v;
        logic [IDX_W-1:0]     idx;
        logic                 err;
        logic [RUN_CNT_W-1:0] n;        // vertices so far in the run, this one included
        logic [BASE_W-1:0]    base;
        logic                 fan;
        logic                 parity;   // strip winding after this vertex
    } t_job;

    typedef struct packed {
        logic              err;
        logic [VNUM_W-1:0] num;
    } t_num;

    // Absolute vertex number, saturated at the top of the output numbering
    function automatic t_num abs_num(input logic [BASE_W-1:0] base,
                                     input logic [RUN_CNT_W-1:0] off);
        logic [BASE_W:0] sum;
        t_num            r;
        sum = {1'b0, base} + (BASE_W + 1)'(off);
        if (sum >= (BASE_W + 1)'(OUT_MAX)) begin
            r.err = 1'b1;
            r.num = VNUM_W'(OUT_MAX - 1);
        end else begin
            r.err = 1'b0;
            r.num = sum[VNUM_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/sfca_front.sv]
module sfca_front
    import sfca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_word_vld,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_push,
    output t_job              o_job
);

    localparam logic [1:0] PH_COUNT = 2'd0;
    localparam logic [1:0] PH_U     = 2'd1;
    localparam logic [1:0] PH_V     = 2'd2;
    localparam logic [1:0] PH_INDEX = 2'd3;

    logic [1:0]           r_phase, n_phase;
    logic [RUN_CNT_W-1:0] r_remain, n_remain;
    logic [RUN_CNT_W-1:0] r_count, n_count;
    logic                 r_parity, n_parity;
    logic                 r_fan, n_fan;
    logic [BASE_W-1:0]    r_base, n_base;
    logic                 r_clamped, n_clamped;
    logic [WORD_W-1:0]    r_u, n_u;
    logic [WORD_W-1:0]    r_v, n_v;

    logic [WORD_W-1:0]    mag;
    logic [BASE_W:0]      nb;
    logic [RUN_CNT_W-1:0] vn;
    logic [RUN_CNT_W-1:0] rem_dec;

    // Word classification and run bookkeeping
    always_comb begin
        n_phase   = r_phase;
        n_remain  = r_remain;
        n_count   = r_count;
        n_parity  = r_parity;
        n_fan     = r_fan;
        n_base    = r_base;
        n_clamped = r_clamped;
        n_u       = r_u;
        n_v       = r_v;
        o_push    = 1'b0;
        o_job     = '0;

        mag     = i_word[WORD_W-1] ? (WORD_W'(0) - i_word) : i_word;
        nb      = {1'b0, r_base} + (BASE_W + 1)'(r_count);
        vn      = r_count + RUN_CNT_W'(1);
        rem_dec = (r_remain != '0) ? (r_remain - RUN_CNT_W'(1)) : r_remain;

        if (i_word_vld) begin
            case (r_phase)
                PH_COUNT: begin
                    if (i_word == '0) begin
                        // list end
                        o_push      = 1'b1;
                        o_job.kind  = KIND_LIST_END;
                        n_base      = '0;
                        n_count     = '0;
                        n_fan       = 1'b0;
                        n_parity    = 1'b1;
                        n_clamped   = 1'b0;
                        n_remain    = '0;
                    end else begin
                        n_fan = i_word[WORD_W-1];
                        if (mag > WORD_W'(RUN_MAX)) begin
                            n_remain  = RUN_CNT_W'(RUN_MAX);
                            n_clamped = 1'b1;
                        end else begin
                            n_remain  = mag[RUN_CNT_W-1:0];
                            n_clamped = 1'b0;
                        end
                        n_base   = (nb > (BASE_W + 1)'(OUT_MAX)) ? BASE_W'(OUT_MAX)
                                                               : nb[BASE_W-1:0];
                        n_count  = '0;
                        n_parity = 1'b1;
                        n_phase  = PH_U;
                    end
                end
                PH_U: begin
                    n_u     = i_word;
                    n_phase = PH_V;
                end
                PH_V: begin
                    n_v     = i_word;
                    n_phase = PH_INDEX;
                end
                PH_INDEX: begin
                    o_push     = 1'b1;
                    o_job.kind = KIND_VERTEX;
                    o_job.u    = r_u;
                    o_job.v    = r_v;
                    o_job.err  = r_clamped;
                    if (i_word[WORD_W-1]) begin
                        o_job.idx = '0;
                        o_job.err = 1'b1;
                    end else if (i_word >= WORD_W'(SRC_MAX)) begin
                        o_job.idx = IDX_W'(SRC_MAX - 1);
                        o_job.err = 1'b1;
                    end else begin
                        o_job.idx = i_word[IDX_W-1:0];
                    end
                    if (vn >= RUN_CNT_W'(3) && !r_fan) begin
                        n_parity = ~r_parity;
                    end
                    o_job.n      = vn;
                    o_job.base   = r_base;
                    o_job.fan    = r_fan;
                    o_job.parity = n_parity;
                    n_count      = vn;
                    n_remain     = rem_dec;
                    n_phase      = (rem_dec == '0) ? PH_COUNT : PH_U;
                end
                default: n_phase = PH_COUNT;
            endcase
        end
    end

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_COUNT;
            r_remain  <= '0;
            r_count   <= '0;
            r_parity  <= 1'b1;
            r_fan     <= 1'b0;
            r_base    <= '0;
            r_clamped <= 1'b0;
            r_u       <= '0;
            r_v       <= '0;
        end else begin
            r_phase   <= n_phase;
            r_remain  <= n_remain;
            r_count   <= n_count;
            r_parity  <= n_parity;
            r_fan     <= n_fan;
            r_base    <= n_base;
            r_clamped <= n_clamped;
            r_u       <= n_u;
            r_v       <= n_v;
        end
    end

endmodule

[rtl/core/sfca_queue.sv]
module sfca_queue
    import sfca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_vld,
    output t_job o_job
);

    // two-entry job queue
    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_job  = r_mem[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && !(i_push && o_full))
        else $error("job queue overflow");

endmodule

[rtl/core/sfca_back.sv]
module sfca_back
    import sfca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_vld,
    input  t_job                   i_job,
    output logic                   o_pop,
    output logic                   o_tvalid,
    input  logic                   i_tready,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tuser
);

    logic                   r_vld;
    logic                   r_kind;
    logic [WORD_W-1:0]      r_u, r_v;
    logic [IDX_W-1:0]       r_idx;
    logic [VNUM_W-1:0]      r_vnum, r_a, r_b, r_c;
    logic                   r_tri, r_err;

    t_num                   s0, s1, s2, s3;
    logic                   tri_en;
    logic [VNUM_W-1:0]      a, b, c;
    logic                   err;

    assign o_pop = i_job_vld && (!r_vld || i_tready);

    // triangle numbering for the vertex at the head of the queue
    always_comb begin
        s0     = abs_num(i_job.base, '0);
        s1     = abs_num(i_job.base, i_job.n - RUN_CNT_W'(1));
        s2     = abs_num(i_job.base, i_job.n - RUN_CNT_W'(2));
        s3     = abs_num(i_job.base, i_job.n - RUN_CNT_W'(3));
        tri_en = (i_job.n >= RUN_CNT_W'(3));
        a      = '0;
        b      = '0;
        c      = '0;
        err    = i_job.err | s1.err;
        if (tri_en) begin
            if (i_job.fan) begin
                a   = s0.num;
                b   = s1.num;
                c   = s2.num;
                err = err | s0.err | s2.err;
            end else begin
                if (i_job.parity) begin
                    a = s3.num;
                    b = s2.num;
                    c = s1.num;
                end else begin
                    a = s1.num;
                    b = s2.num;
                    c = s3.num;
                end
                err = err | s2.err | s3.err;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_pop) begin
            r_vld <= 1'b1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_job.kind;
            if (i_job.kind == KIND_LIST_END) begin
                r_u    <= '0;
                r_v    <= '0;
                r_idx  <= '0;
                r_vnum <= '0;
                r_tri  <= 1'b0;
                r_a    <= '0;
                r_b    <= '0;
                r_c    <= '0;
                r_err  <= 1'b0;
            end else begin
                r_u    <= i_job.u;
                r_v    <= i_job.v;
                r_idx  <= i_job.idx;
                r_vnum <= s1.num;
                r_tri  <= tri_en;
                r_a    <= a;
                r_b    <= b;
                r_c    <= c;
                r_err  <= err;
            end
        end
    end

    assign o_tvalid = r_vld;
    assign o_tuser  = r_kind;
    assign o_tdata  = {4'b0, r_err, r_c, r_b, r_a, r_tri, r_vnum, r_idx, r_v, r_u};

    a_no_tri_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_tri |-> (r_a == '0) && (r_b == '0) && (r_c == '0))
        else $error("triangle fields set without a triangle");

    a_tri_has_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_tri |-> (r_a == r_vnum) || (r_b == r_vnum) || (r_c == r_vnum))
        else $error("triangle does not contain the emitted vertex");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && (r_kind == KIND_LIST_END) |-> (r_vnum == '0) && !r_err && !r_tri)
        else $error("list end carries vertex data");

endmodule

[rtl/core/strip_fan_command_assembler.sv]
// Channel   Dir  Handshake               Payload
// s         in   i_s_tvalid/o_s_tready   tdata: command_word
// m         out  o_m_tvalid/i_m_tready   tdata: vertex and triangle, tuser: out_kind
//
// One command word is taken per cycle while o_s_tready is high; each index word
// or zero count word yields one result. The front tracks the word phase, a
// two-entry job queue decouples it from the back, which numbers the triangle
// and holds the result in an output register. Reset is synchronous and clears
// all run state; a stalled output fills the queue and then drops o_s_tready.
module strip_fan_command_assembler
    import sfca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [WORD_W-1:0]      i_s_tdata,   // [31:0] command_word
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [31:0] tex_u_bits, [63:32] tex_v_bits, [73:64] vertex_index,
    // [89:74] vertex_number, [90] tri_valid, [106:91] tri_a, [122:107] tri_b,
    // [138:123] tri_c, [139] range_error, [143:140] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser    // [0] out_kind
);

    logic q_full, q_vld, push, pop;
    t_job job_in, job_out;

    assign o_s_tready = !q_full;

    sfca_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word_vld (i_s_tvalid && !q_full),
        .i_word     (i_s_tdata),
        .o_push     (push),
        .o_job      (job_in)
    );

    sfca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_job   (job_out)
    );

    sfca_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (q_vld),
        .i_job     (job_out),
        .o_pop     (pop),
        .o_tvalid  (o_m_tvalid),
        .i_tready  (i_m_tready),
        .o_tdata   (o_m_tdata),
        .o_tuser   (o_m_tuser)
    );

endmodule
